// ===== sv/atrp_pkg.sv =====
// ----------------------------------------------------------------------------
// atrp_pkg
// Shared types and codes for the ASCII TLV record parser.
// ----------------------------------------------------------------------------
package atrp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] EV_HEADER = 3'd0;
  localparam logic [2:0] EV_DATA   = 3'd1;
  localparam logic [2:0] EV_EMPTY  = 3'd2;
  localparam logic [2:0] EV_DONE   = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR = 3'd1;
  localparam logic [2:0] ERR_COUNT     = 3'd2;
  localparam logic [2:0] ERR_TYPE_LEN  = 3'd3;
  localparam logic [2:0] ERR_DATA_CHAR = 3'd4;
  localparam logic [2:0] ERR_TRUNC     = 3'd5;

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_NUL  = 8'd0;

  localparam logic [3:0] HDR_LAST_POS = 4'd9;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_SKIP_LINE,
    PH_SKIP_EOL,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_DRAIN
  } phase_t;

  // One queue entry: a first result word, plus an optional trailing
  // done/error word that shares its context fields.
  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] rec_kind;
    logic [7:0] rec_version;
    logic [9:0] total;
    logic [9:0] elem_kind;
    logic [9:0] elem_length;
    logic [9:0] idx;
    logic [7:0] dbyte;
    logic       known;
    logic       elem_end;
    logic [2:0] err;
    logic       two;
    logic [2:0] err2;
  } res_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/atrp_front.sv =====
// ----------------------------------------------------------------------------
// atrp_front
// Byte classifier and parse state; builds at most one queue entry per input byte.
// ----------------------------------------------------------------------------
module atrp_front
  import atrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eob,
  input  q_status_t  q_stat,
  output logic       push,
  output res_entry_t push_data
);

  phase_t     phase, phase_next;
  logic [3:0] pos, pos_next;
  logic [9:0] acc, acc_next;
  logic [9:0] left, left_next;
  logic [9:0] cur_kind, cur_kind_next;
  logic [9:0] cur_len, cur_len_next;
  logic [9:0] dpos, dpos_next;
  logic [7:0] hdr_kind, hdr_kind_next;
  logic [7:0] hdr_ver, hdr_ver_next;
  logic [9:0] total, total_next;
  logic       failed, failed_next;

  function automatic logic [9:0] mac10(input logic [9:0] a, input logic [7:0] dd);
    mac10 = 10'({a, 3'b000} + {2'b00, a, 1'b0} + {5'b00000, dd});
  endfunction

  function automatic logic is_known(input logic [9:0] k);
    is_known = (k >= 10'd1 && k <= 10'd4) || (k >= 10'd6 && k <= 10'd12);
  endfunction

  logic       take;
  logic [7:0] d;
  logic       dig, eol;
  logic       do_type;
  logic [3:0] pos_t;
  logic [9:0] acc_t, sum;
  logic       has0, fin, restart, endb, do_complete;
  logic [2:0] fin_err;
  logic [2:0] e_ev, e_err;
  logic [9:0] e_idx;
  logic [7:0] e_byte;
  logic       e_end;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;
  assign d        = in_byte - CH_ZERO;
  assign dig      = (d <= 8'd9);
  assign eol      = (in_byte == CH_CR) || (in_byte == CH_LF);

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    acc_next      = acc;
    left_next     = left;
    cur_kind_next = cur_kind;
    cur_len_next  = cur_len;
    dpos_next     = dpos;
    hdr_kind_next = hdr_kind;
    hdr_ver_next  = hdr_ver;
    total_next    = total;
    failed_next   = failed;
    do_type       = 1'b0;
    pos_t         = pos;
    acc_t         = acc;
    sum           = '0;
    has0          = 1'b0;
    fin           = 1'b0;
    fin_err       = ERR_NONE;
    restart       = 1'b0;
    endb          = 1'b0;
    do_complete   = 1'b0;
    e_ev          = EV_HEADER;
    e_err         = ERR_NONE;
    e_idx         = '0;
    e_byte        = '0;
    e_end         = 1'b0;
    push_data     = '0;
    push          = 1'b0;

    if (take) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos == 4'd0) begin
            hdr_kind_next = d;
          end else if (pos == 4'd1) begin
            hdr_ver_next = d;
          end else if (pos <= 4'd4) begin
            if (dig) begin
              acc_next = mac10(acc, d);
            end else begin
              failed_next = 1'b1;
            end
          end
          if (pos < HDR_LAST_POS) begin
            if (in_eob) begin
              fin     = 1'b1;
              fin_err = ERR_SHORT_HDR;
            end else begin
              pos_next = pos + 4'd1;
            end
          end else if (failed) begin
            fin     = 1'b1;
            fin_err = ERR_COUNT;
          end else begin
            total_next = acc;
            left_next  = acc;
            acc_next   = '0;
            pos_next   = '0;
            has0       = 1'b1;
            e_ev       = EV_HEADER;
            if (in_eob) begin
              fin     = 1'b1;
              fin_err = (acc != 10'd0) ? ERR_TRUNC : ERR_NONE;
            end else if (acc == 10'd0) begin
              fin = 1'b1;
            end else begin
              phase_next = PH_SKIP_LINE;
            end
          end
        end
        PH_SKIP_LINE: begin
          if (eol) begin
            phase_next = PH_SKIP_EOL;
          end
          if (in_eob) begin
            fin     = 1'b1;
            fin_err = (left == total) ? ERR_TRUNC : ERR_NONE;
          end
        end
        PH_SKIP_EOL: begin
          if (eol) begin
            if (in_eob) begin
              fin     = 1'b1;
              fin_err = (left == total) ? ERR_TRUNC : ERR_NONE;
            end
          end else begin
            do_type = 1'b1;
            pos_t   = '0;
            acc_t   = '0;
          end
        end
        PH_TYPE: begin
          do_type = 1'b1;
        end
        PH_LEN: begin
          if (!dig) begin
            fin     = 1'b1;
            fin_err = ERR_TYPE_LEN;
          end else begin
            sum = mac10(acc, d);
            if (pos < 4'd2) begin
              pos_next = pos + 4'd1;
              acc_next = sum;
              if (in_eob) begin
                fin     = 1'b1;
                fin_err = ERR_TRUNC;
              end
            end else begin
              cur_len_next = sum;
              acc_next     = '0;
              pos_next     = '0;
              dpos_next    = '0;
              if (sum == 10'd0) begin
                has0        = 1'b1;
                e_ev        = EV_EMPTY;
                do_complete = 1'b1;
              end else begin
                phase_next = PH_DATA;
                if (in_eob) begin
                  fin     = 1'b1;
                  fin_err = ERR_TRUNC;
                end
              end
            end
          end
        end
        PH_DATA: begin
          if (in_byte == CH_NUL || eol) begin
            fin     = 1'b1;
            fin_err = ERR_DATA_CHAR;
          end else begin
            endb   = ({1'b0, dpos} + 11'd1) >= {1'b0, cur_len};
            has0   = 1'b1;
            e_ev   = EV_DATA;
            e_idx  = dpos;
            e_byte = in_byte;
            e_end  = endb;
            if (endb) begin
              do_complete = 1'b1;
            end else if (in_eob) begin
              fin     = 1'b1;
              fin_err = ERR_TRUNC;
            end else begin
              dpos_next = dpos + 10'd1;
            end
          end
        end
        PH_DRAIN: begin
          restart = in_eob;
        end
        default: begin
          restart = in_eob;
        end
      endcase

      if (do_type) begin
        phase_next = PH_TYPE;
        pos_next   = pos_t;
        acc_next   = acc_t;
        if (pos_t == 4'd0 && in_byte == CH_NUL) begin
          fin = 1'b1;
        end else if (!dig) begin
          fin     = 1'b1;
          fin_err = ERR_TYPE_LEN;
        end else begin
          sum = mac10(acc_t, d);
          if (pos_t >= 4'd2) begin
            cur_kind_next = sum;
            acc_next      = '0;
            pos_next      = '0;
            phase_next    = PH_LEN;
          end else begin
            acc_next = sum;
            pos_next = pos_t + 4'd1;
          end
          if (in_eob) begin
            fin     = 1'b1;
            fin_err = ERR_TRUNC;
          end
        end
      end

      if (do_complete) begin
        if (left != 10'd0) begin
          left_next = left - 10'd1;
        end
        if (left_next == 10'd0 || in_eob) begin
          fin = 1'b1;
        end else begin
          phase_next = PH_SKIP_LINE;
        end
      end

      if (fin) begin
        if (has0) begin
          push_data.two  = 1'b1;
          push_data.err2 = fin_err;
        end else begin
          has0  = 1'b1;
          e_ev  = (fin_err != ERR_NONE) ? EV_ERROR : EV_DONE;
          e_err = fin_err;
        end
        if (in_eob) begin
          restart = 1'b1;
        end else begin
          phase_next = PH_DRAIN;
        end
      end

      push                  = has0;
      push_data.ev          = e_ev;
      push_data.rec_kind    = hdr_kind_next;
      push_data.rec_version = hdr_ver_next;
      push_data.total       = total_next;
      push_data.elem_kind   = cur_kind_next;
      push_data.elem_length = cur_len_next;
      push_data.idx         = e_idx;
      push_data.dbyte       = e_byte;
      push_data.known       = (e_ev == EV_DATA || e_ev == EV_EMPTY) && is_known(cur_kind_next);
      push_data.elem_end    = e_end;
      push_data.err         = e_err;

      if (restart) begin
        phase_next    = PH_HEADER;
        pos_next      = '0;
        acc_next      = '0;
        left_next     = '0;
        cur_kind_next = '0;
        cur_len_next  = '0;
        dpos_next     = '0;
        hdr_kind_next = '0;
        hdr_ver_next  = '0;
        total_next    = '0;
        failed_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      acc      <= '0;
      left     <= '0;
      cur_kind <= '0;
      cur_len  <= '0;
      dpos     <= '0;
      hdr_kind <= '0;
      hdr_ver  <= '0;
      total    <= '0;
      failed   <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      acc      <= acc_next;
      left     <= left_next;
      cur_kind <= cur_kind_next;
      cur_len  <= cur_len_next;
      dpos     <= dpos_next;
      hdr_kind <= hdr_kind_next;
      hdr_ver  <= hdr_ver_next;
      total    <= total_next;
      failed   <= failed_next;
    end
  end

endmodule

// ===== sv/atrp_queue.sv =====
// ----------------------------------------------------------------------------
// atrp_queue
// Short entry queue between the parse front and the output back.
// ----------------------------------------------------------------------------
module atrp_queue
  import atrp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  res_entry_t push_data,
  input  logic       pop,
  output res_entry_t head,
  output q_status_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_entry_t      mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/atrp_back.sv =====
// ----------------------------------------------------------------------------
// atrp_back
// Output side: expands each queue entry into one or two result words.
// ----------------------------------------------------------------------------
module atrp_back
  import atrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  res_entry_t  head,
  input  q_status_t   q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [71:0] out_data,
  output logic [2:0]  out_user,
  output logic        out_last
);

  logic       second, second_next;
  logic       sent;
  logic [2:0] ev;
  logic [9:0] idx;
  logic [7:0] dbyte;
  logic       known, elem_end;
  logic [2:0] err;

  assign out_valid = !q_stat.empty;
  assign sent      = out_valid && out_ready;
  assign pop       = sent && (second || !head.two);

  always_comb begin
    second_next = second;
    if (sent) begin
      second_next = second ? 1'b0 : head.two;
    end
    if (second) begin
      ev       = (head.err2 != ERR_NONE) ? EV_ERROR : EV_DONE;
      idx      = '0;
      dbyte    = '0;
      known    = 1'b0;
      elem_end = 1'b0;
      err      = head.err2;
      out_last = 1'b1;
    end else begin
      ev       = head.ev;
      idx      = head.idx;
      dbyte    = head.dbyte;
      known    = head.known;
      elem_end = head.elem_end;
      err      = head.err;
      out_last = !head.two;
    end
  end

  assign out_user = ev;
  assign out_data = {3'b000, err, elem_end, known, dbyte, idx, head.elem_length,
                     head.elem_kind, head.total, head.rec_version, head.rec_kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= second_next;
    end
  end

endmodule

// ===== sv/ascii_tlv_record_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_tlv_record_parser
// Byte-serial parser for ASCII type/length/value system-information records.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the entry queue is not full; each
// byte yields zero, one or two words. The first word of a byte is registered
// in the entry queue that separates the parse state from the output.
// The parse state updates once per taken byte; a byte yielding two words holds
// the output side until both are sent. Reset clears parse state and queue.
// ----------------------------------------------------------------------------
module ascii_tlv_record_parser
  import atrp_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // record_kind, record_version, element_total, element_kind, element_size,
  // byte_index, data_byte, known_kind, element_end, error_code, zero pad
  output logic [71:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // event_res
  output logic        m_axis_tlast    // last
);

  q_status_t  q_stat;
  res_entry_t push_data, head;
  logic       push, pop;

  atrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_eob    (s_axis_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  atrp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  atrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_DONE || m_axis_tuser == EV_ERROR)
      |-> m_axis_tlast)
    else $error("done/error word not marked last");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == EV_ERROR |-> m_axis_tdata[68:66] != ERR_NONE)
    else $error("error word without error code");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_stat.full && !q_stat.empty)
    else $error("input stalled with queue space");

  a_pop_after_push: assert property (@(posedge clk) disable iff (rst)
    push && s_axis_tvalid && s_axis_tready |=> !q_stat.empty)
    else $error("pushed entry missing from queue");

endmodule
